FILE: src/sbnd_pkg.sv
// Shared constants and types for the bandpass normalize decimate block.
package sbnd_pkg;

  localparam int CHANNELS    = 128;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int PAIRS       = (CHANNELS + 1) / 2;
  localparam int PAIR_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int MAX_DECIM   = 1024;
  localparam int DEC_W       = 11;
  localparam int GRP_W       = $clog2(MAX_DECIM) > 0 ? $clog2(MAX_DECIM) : 1;
  localparam int COUNT_BITS  = 24;
  localparam int LVL_W       = 8;
  localparam int SUM_W       = 32;
  localparam int Q_W         = 32;
  localparam int ACC_W       = 48;
  localparam int S_W         = Q_W + CH_W;
  localparam int DIV_NW      = S_W + 17;
  localparam int DIV_DW      = S_W + 1;
  localparam int DIV_CW      = $clog2(DIV_NW);
  localparam int REG_W       = 2;
  localparam int CFG_W       = 11;

  localparam logic [REG_W-1:0] REG_DECIM = 2'd0;
  localparam logic [REG_W-1:0] REG_BP    = 2'd1;
  localparam logic [REG_W-1:0] REG_TD    = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_L_RD, ST_L_WR, ST_P_WR,
    ST_A_RD, ST_A_LD, ST_A_WAIT, ST_A_WR,
    ST_B_RD, ST_B_LD, ST_B_WAIT, ST_B_WR,
    ST_DEC,
    ST_C_RDE, ST_C_LDE, ST_C_WE, ST_C_SE,
    ST_C_RDO, ST_C_LDO, ST_C_WO, ST_C_OUT, ST_C_HOLD
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_LEARN_WR, OP_BUF_WR,
    OP_A_LOAD, OP_A_WR, OP_B_LOAD, OP_B_WR, OP_DEC,
    OP_C_LOAD, OP_C_SAVE, OP_C_OUT, OP_C_NEXT, OP_C_END
  } op_e;

  typedef struct packed {
    op_e  op;
    logic pair_addr;
    logic odd_sel;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic cnt_last;
    logic pair_last;
    logic div_busy;
    logic emit;
    logic out_busy;
  } stat_t;

endpackage

FILE: src/sbnd_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sbnd_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/sbnd_div.sv
// Restoring divider, one quotient bit per cycle.
module sbnd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sbnd_pkg::DIV_NW-1:0] num_i,
  input  logic [sbnd_pkg::DIV_DW-1:0] den_i,
  output logic                       busy_o,
  output logic [sbnd_pkg::DIV_NW-1:0] quo_o
);

  logic                        busy_q, busy_d;
  logic [sbnd_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic [sbnd_pkg::DIV_DW-1:0] rem_q, rem_d;
  logic [sbnd_pkg::DIV_DW-1:0] den_q, den_d;
  logic [sbnd_pkg::DIV_NW-1:0] quo_q, quo_d;
  logic [sbnd_pkg::DIV_DW:0]   trial;
  logic [sbnd_pkg::DIV_DW:0]   diff;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[sbnd_pkg::DIV_NW-1]};
    diff   = trial - {1'b0, den_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[sbnd_pkg::DIV_DW-1:0];
        quo_d = {quo_q[sbnd_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = trial[sbnd_pkg::DIV_DW-1:0];
        quo_d = {quo_q[sbnd_pkg::DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == sbnd_pkg::DIV_CW'(sbnd_pkg::DIV_NW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

FILE: src/sbnd_dp.sv
// Datapath: configuration, stores, shared divider and output register.
module sbnd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sbnd_pkg::cmd_t                cmd_i,
  output sbnd_pkg::stat_t               stat_o,
  input  logic                          mode_i,
  input  logic signed [7:0]             sample_i,
  input  logic                          cfg_valid_i,
  input  logic [sbnd_pkg::REG_W-1:0]    cfg_index_i,
  input  logic [sbnd_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [5:0]                    pair_index_o,
  output logic [31:0]                   value_even_o,
  output logic [31:0]                   value_odd_o,
  output logic                          saturated_o,
  output logic                          last_pair_o
);

  localparam int CH   = sbnd_pkg::CHANNELS;
  localparam int CW   = sbnd_pkg::CH_W;
  localparam int QW   = sbnd_pkg::Q_W;
  localparam int AW   = sbnd_pkg::ACC_W;
  localparam int SW   = sbnd_pkg::S_W;
  localparam int NW   = sbnd_pkg::DIV_NW;
  localparam int DW   = sbnd_pkg::DIV_DW;
  localparam int LW   = sbnd_pkg::LVL_W;
  localparam int UW   = sbnd_pkg::SUM_W;
  localparam int KW   = sbnd_pkg::COUNT_BITS;
  localparam int GW   = sbnd_pkg::GRP_W;
  localparam int DCW  = sbnd_pkg::DEC_W;

  logic [DCW-1:0] decim_q, decim_d;
  logic           bp_q, bp_d, td_q, td_d;

  logic           prev_q, prev_d;
  logic [CW-1:0]  chpos_q, chpos_d;
  logic [GW-1:0]  grp_q, grp_d;
  logic [KW-1:0]  learned_q, learned_d;
  logic [CH-1:0]  sums_vld_q, sums_vld_d;
  logic [CH-1:0]  acc_vld_q, acc_vld_d;
  logic           out_valid_q, out_valid_d;

  logic           mode_q, mode_d, last_q, last_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic [LW-1:0]  lvl_q, lvl_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [SW-1:0]  ssum_q, ssum_d;
  logic [QW-1:0]  x_q, x_d, ve_q, ve_d;
  logic           f_q, f_d, use_div_q, use_div_d, sf_q, sf_d;

  logic [5:0]     opair_q, opair_d;
  logic [QW-1:0]  oeven_q, oeven_d, oodd_q, oodd_d;
  logic           osat_q, osat_d, olast_q, olast_d;

  logic [UW-1:0]  sums_rdata, sums_wdata;
  logic [CW-1:0]  sums_raddr;
  logic [LW-1:0]  buf_rdata;
  logic [QW:0]    x_rdata, x_wdata;
  logic [AW:0]    acc_rdata, acc_wdata;
  logic [CW-1:0]  acc_raddr;

  logic           div_start, div_busy;
  logic [NW-1:0]  div_num, div_quo;
  logic [DW-1:0]  div_den;

  logic [LW-1:0]  s_u;
  logic [LW-1:0]  in_lvl;
  logic           chg;
  logic [CW-1:0]  in_pos;
  logic           in_last;
  logic [DCW-1:0] d_eff;
  logic           emit;
  logic [UW-1:0]  sum_old;
  logic [UW:0]    sum_new;
  logic           div_over;
  logic [QW-1:0]  div_clamp;
  logic [QW-1:0]  x_eff;
  logic           f_eff;
  logic [QW+KW-1:0] lv_prod;
  logic [SW-1:0]  x_mul;
  logic [AW-1:0]  acc_old;
  logic           acc_old_sat;
  logic [AW:0]    acc_sum;
  logic [CW:0]    odd_idx;
  logic           odd_ok;

  assign s_u     = LW'(sample_i);
  assign in_lvl  = s_u[LW-1] ? s_u - 1'b1 : s_u;
  assign chg     = (mode_i != prev_q);
  assign in_pos  = chg ? '0 : chpos_q;
  assign in_last = (in_pos == CW'(CH - 1));

  always_comb begin
    if (decim_q == '0) begin
      d_eff = DCW'(1);
    end else if (decim_q > DCW'(sbnd_pkg::MAX_DECIM)) begin
      d_eff = DCW'(sbnd_pkg::MAX_DECIM);
    end else begin
      d_eff = decim_q;
    end
  end
  assign emit = ((DCW'(grp_q) + 1'b1) >= d_eff);

  assign sums_raddr = mode_q ? cnt_q : pos_q;
  assign acc_raddr  = cmd_i.pair_addr ? {cnt_q[CW-2:0], cmd_i.odd_sel} : cnt_q;
  assign odd_idx    = {cnt_q, 1'b1};
  assign odd_ok     = (odd_idx < (CW + 1)'(CH));

  assign sum_old  = sums_vld_q[pos_q] ? sums_rdata : '0;
  assign sum_new  = {1'b0, sum_old} + (UW + 1)'(lvl_q);
  assign sums_wdata = sum_new[UW] ? '1 : sum_new[UW-1:0];

  assign div_over  = |div_quo[NW-1:QW];
  assign div_clamp = div_over ? '1 : div_quo[QW-1:0];
  assign x_eff     = use_div_q ? div_clamp : x_q;
  assign f_eff     = f_q | (use_div_q & div_over);

  assign lv_prod = (QW + KW)'(buf_rdata) * (QW + KW)'(learned_q);
  assign x_mul   = SW'(x_rdata[QW-1:0]) * SW'(CH);

  assign acc_old     = acc_vld_q[acc_raddr] ? acc_rdata[AW-1:0] : '0;
  assign acc_old_sat = acc_vld_q[acc_raddr] ? acc_rdata[AW] : 1'b0;
  assign acc_sum     = {1'b0, acc_old} + (AW + 1)'(x_eff);
  assign acc_wdata   = {acc_old_sat | f_eff, acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0]};
  assign x_wdata     = {f_eff, x_eff};

  always_comb begin
    decim_d     = decim_q;
    bp_d        = bp_q;
    td_d        = td_q;
    prev_d      = prev_q;
    chpos_d     = chpos_q;
    grp_d       = grp_q;
    learned_d   = learned_q;
    sums_vld_d  = sums_vld_q;
    acc_vld_d   = acc_vld_q;
    out_valid_d = out_valid_q;
    mode_d      = mode_q;
    last_d      = last_q;
    pos_d       = pos_q;
    lvl_d       = lvl_q;
    cnt_d       = cnt_q;
    ssum_d      = ssum_q;
    x_d         = x_q;
    f_d         = f_q;
    use_div_d   = use_div_q;
    ve_d        = ve_q;
    sf_d        = sf_q;
    opair_d     = opair_q;
    oeven_d     = oeven_q;
    oodd_d      = oodd_q;
    osat_d      = osat_q;
    olast_d     = olast_q;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sbnd_pkg::REG_DECIM: decim_d = cfg_data_i;
        sbnd_pkg::REG_BP:    bp_d    = cfg_data_i[0];
        sbnd_pkg::REG_TD:    td_d    = cfg_data_i[0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (cmd_i.op)
      sbnd_pkg::OP_ACCEPT: begin
        if (chg) begin
          acc_vld_d = '0;
          grp_d     = '0;
        end
        prev_d  = mode_i;
        chpos_d = in_last ? '0 : in_pos + 1'b1;
        mode_d  = mode_i;
        last_d  = in_last;
        pos_d   = in_pos;
        lvl_d   = in_lvl;
      end
      sbnd_pkg::OP_LEARN_WR: begin
        sums_vld_d[pos_q] = 1'b1;
        if (last_q && (learned_q != {KW{1'b1}})) begin
          learned_d = learned_q + 1'b1;
        end
      end
      sbnd_pkg::OP_BUF_WR: begin
        cnt_d  = '0;
        ssum_d = '0;
      end
      sbnd_pkg::OP_A_LOAD: begin
        f_d       = 1'b0;
        use_div_d = 1'b0;
        if (!bp_q) begin
          x_d = {buf_rdata, 16'b0};
        end else if (!sums_vld_q[cnt_q] || (sums_rdata == '0)) begin
          x_d = '1;
          f_d = 1'b1;
        end else begin
          use_div_d = 1'b1;
          div_start = 1'b1;
          div_num   = NW'({lv_prod, 16'b0});
          div_den   = DW'(sums_rdata);
        end
      end
      sbnd_pkg::OP_A_WR: begin
        ssum_d = ssum_q + SW'(x_eff);
        cnt_d  = (cnt_q == CW'(CH - 1)) ? '0 : cnt_q + 1'b1;
      end
      sbnd_pkg::OP_B_LOAD: begin
        f_d       = x_rdata[QW];
        use_div_d = 1'b0;
        if (!td_q) begin
          x_d = x_rdata[QW-1:0];
        end else if (ssum_q == '0) begin
          x_d = '1;
          f_d = 1'b1;
        end else begin
          use_div_d = 1'b1;
          div_start = 1'b1;
          div_num   = NW'({x_mul, 16'b0});
          div_den   = DW'(ssum_q);
        end
      end
      sbnd_pkg::OP_B_WR: begin
        acc_vld_d[cnt_q] = 1'b1;
        cnt_d = (cnt_q == CW'(CH - 1)) ? '0 : cnt_q + 1'b1;
      end
      sbnd_pkg::OP_DEC: begin
        if (emit) begin
          cnt_d = '0;
        end else begin
          grp_d = grp_q + 1'b1;
        end
      end
      sbnd_pkg::OP_C_LOAD: begin
        div_start = 1'b1;
        use_div_d = 1'b1;
        div_num   = NW'(acc_old);
        div_den   = DW'(d_eff);
        if (cmd_i.odd_sel) begin
          sf_d = sf_q | (odd_ok & acc_old_sat);
        end else begin
          sf_d = acc_old_sat;
        end
      end
      sbnd_pkg::OP_C_SAVE: begin
        ve_d = div_clamp;
        sf_d = sf_q | div_over;
      end
      sbnd_pkg::OP_C_OUT: begin
        opair_d     = 6'(cnt_q);
        oeven_d     = ve_q;
        oodd_d      = odd_ok ? div_clamp : '0;
        osat_d      = sf_q | (odd_ok & div_over);
        olast_d     = (cnt_q == CW'(sbnd_pkg::PAIRS - 1));
        out_valid_d = 1'b1;
      end
      sbnd_pkg::OP_C_NEXT: begin
        cnt_d = cnt_q + 1'b1;
      end
      sbnd_pkg::OP_C_END: begin
        acc_vld_d = '0;
        grp_d     = '0;
        cnt_d     = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q     <= DCW'(1);
      bp_q        <= 1'b0;
      td_q        <= 1'b0;
      prev_q      <= 1'b0;
      chpos_q     <= '0;
      grp_q       <= '0;
      learned_q   <= '0;
      sums_vld_q  <= '0;
      acc_vld_q   <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      last_q      <= 1'b0;
      pos_q       <= '0;
      cnt_q       <= '0;
      ssum_q      <= '0;
      use_div_q   <= 1'b0;
    end else begin
      decim_q     <= decim_d;
      bp_q        <= bp_d;
      td_q        <= td_d;
      prev_q      <= prev_d;
      chpos_q     <= chpos_d;
      grp_q       <= grp_d;
      learned_q   <= learned_d;
      sums_vld_q  <= sums_vld_d;
      acc_vld_q   <= acc_vld_d;
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      last_q      <= last_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      ssum_q      <= ssum_d;
      use_div_q   <= use_div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    x_q     <= x_d;
    f_q     <= f_d;
    ve_q    <= ve_d;
    sf_q    <= sf_d;
    opair_q <= opair_d;
    oeven_q <= oeven_d;
    oodd_q  <= oodd_d;
    osat_q  <= osat_d;
    olast_q <= olast_d;
  end

  sbnd_ram #(.Width(UW), .Depth(CH)) u_sums (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == sbnd_pkg::OP_LEARN_WR),
    .waddr_i (pos_q),
    .wdata_i (sums_wdata),
    .raddr_i (sums_raddr),
    .rdata_o (sums_rdata)
  );

  sbnd_ram #(.Width(LW), .Depth(CH)) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == sbnd_pkg::OP_BUF_WR),
    .waddr_i (pos_q),
    .wdata_i (lvl_q),
    .raddr_i (cnt_q),
    .rdata_o (buf_rdata)
  );

  sbnd_ram #(.Width(QW + 1), .Depth(CH)) u_x (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == sbnd_pkg::OP_A_WR),
    .waddr_i (cnt_q),
    .wdata_i (x_wdata),
    .raddr_i (cnt_q),
    .rdata_o (x_rdata)
  );

  sbnd_ram #(.Width(AW + 1), .Depth(CH)) u_acc (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == sbnd_pkg::OP_B_WR),
    .waddr_i (cnt_q),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  sbnd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign stat_o.mode      = mode_q;
  assign stat_o.last      = last_q;
  assign stat_o.cnt_last  = (cnt_q == CW'(CH - 1));
  assign stat_o.pair_last = (cnt_q == CW'(sbnd_pkg::PAIRS - 1));
  assign stat_o.div_busy  = div_busy;
  assign stat_o.emit      = emit;
  assign stat_o.out_busy  = out_valid_q;

  assign out_valid_o  = out_valid_q;
  assign pair_index_o = opair_q;
  assign value_even_o = oeven_q;
  assign value_odd_o  = oodd_q;
  assign saturated_o  = osat_q;
  assign last_pair_o  = olast_q;

endmodule

FILE: src/sbnd_ctrl.sv
// Controller state machine sequencing learn, buffer and end-of-spectrum passes.
module sbnd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             mode_i,
  output logic             in_stall_o,
  input  sbnd_pkg::stat_t  stat_i,
  output sbnd_pkg::cmd_t   cmd_o
);

  sbnd_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbnd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mode_i ? sbnd_pkg::ST_P_WR : sbnd_pkg::ST_L_RD;
        end
      end
      sbnd_pkg::ST_L_RD:  state_d = sbnd_pkg::ST_L_WR;
      sbnd_pkg::ST_L_WR:  state_d = sbnd_pkg::ST_IDLE;
      sbnd_pkg::ST_P_WR:  state_d = stat_i.last ? sbnd_pkg::ST_A_RD : sbnd_pkg::ST_IDLE;
      sbnd_pkg::ST_A_RD:  state_d = sbnd_pkg::ST_A_LD;
      sbnd_pkg::ST_A_LD:  state_d = sbnd_pkg::ST_A_WAIT;
      sbnd_pkg::ST_A_WAIT: begin
        if (!stat_i.div_busy) state_d = sbnd_pkg::ST_A_WR;
      end
      sbnd_pkg::ST_A_WR:  state_d = stat_i.cnt_last ? sbnd_pkg::ST_B_RD : sbnd_pkg::ST_A_RD;
      sbnd_pkg::ST_B_RD:  state_d = sbnd_pkg::ST_B_LD;
      sbnd_pkg::ST_B_LD:  state_d = sbnd_pkg::ST_B_WAIT;
      sbnd_pkg::ST_B_WAIT: begin
        if (!stat_i.div_busy) state_d = sbnd_pkg::ST_B_WR;
      end
      sbnd_pkg::ST_B_WR:  state_d = stat_i.cnt_last ? sbnd_pkg::ST_DEC : sbnd_pkg::ST_B_RD;
      sbnd_pkg::ST_DEC:   state_d = stat_i.emit ? sbnd_pkg::ST_C_RDE : sbnd_pkg::ST_IDLE;
      sbnd_pkg::ST_C_RDE: state_d = sbnd_pkg::ST_C_LDE;
      sbnd_pkg::ST_C_LDE: state_d = sbnd_pkg::ST_C_WE;
      sbnd_pkg::ST_C_WE: begin
        if (!stat_i.div_busy) state_d = sbnd_pkg::ST_C_SE;
      end
      sbnd_pkg::ST_C_SE:  state_d = sbnd_pkg::ST_C_RDO;
      sbnd_pkg::ST_C_RDO: state_d = sbnd_pkg::ST_C_LDO;
      sbnd_pkg::ST_C_LDO: state_d = sbnd_pkg::ST_C_WO;
      sbnd_pkg::ST_C_WO: begin
        if (!stat_i.div_busy) state_d = sbnd_pkg::ST_C_OUT;
      end
      sbnd_pkg::ST_C_OUT: state_d = sbnd_pkg::ST_C_HOLD;
      sbnd_pkg::ST_C_HOLD: begin
        if (!stat_i.out_busy) begin
          state_d = stat_i.pair_last ? sbnd_pkg::ST_IDLE : sbnd_pkg::ST_C_RDE;
        end
      end
      default: state_d = sbnd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op        = sbnd_pkg::OP_NONE;
    cmd_o.pair_addr = 1'b0;
    cmd_o.odd_sel   = 1'b0;
    in_stall_o      = (state_q != sbnd_pkg::ST_IDLE);
    unique case (state_q)
      sbnd_pkg::ST_IDLE: begin
        if (in_valid_i) cmd_o.op = sbnd_pkg::OP_ACCEPT;
      end
      sbnd_pkg::ST_L_WR:  cmd_o.op = sbnd_pkg::OP_LEARN_WR;
      sbnd_pkg::ST_P_WR:  cmd_o.op = sbnd_pkg::OP_BUF_WR;
      sbnd_pkg::ST_A_LD:  cmd_o.op = sbnd_pkg::OP_A_LOAD;
      sbnd_pkg::ST_A_WAIT: begin
        if (!stat_i.div_busy) cmd_o.op = sbnd_pkg::OP_NONE;
      end
      sbnd_pkg::ST_A_WR:  cmd_o.op = sbnd_pkg::OP_A_WR;
      sbnd_pkg::ST_B_LD:  cmd_o.op = sbnd_pkg::OP_B_LOAD;
      sbnd_pkg::ST_B_WR:  cmd_o.op = sbnd_pkg::OP_B_WR;
      sbnd_pkg::ST_DEC:   cmd_o.op = sbnd_pkg::OP_DEC;
      sbnd_pkg::ST_C_RDE, sbnd_pkg::ST_C_WE: cmd_o.pair_addr = 1'b1;
      sbnd_pkg::ST_C_LDE: begin
        cmd_o.op        = sbnd_pkg::OP_C_LOAD;
        cmd_o.pair_addr = 1'b1;
      end
      sbnd_pkg::ST_C_SE: begin
        cmd_o.op        = sbnd_pkg::OP_C_SAVE;
        cmd_o.pair_addr = 1'b1;
      end
      sbnd_pkg::ST_C_RDO, sbnd_pkg::ST_C_WO: begin
        cmd_o.pair_addr = 1'b1;
        cmd_o.odd_sel   = 1'b1;
      end
      sbnd_pkg::ST_C_LDO: begin
        cmd_o.op        = sbnd_pkg::OP_C_LOAD;
        cmd_o.pair_addr = 1'b1;
        cmd_o.odd_sel   = 1'b1;
      end
      sbnd_pkg::ST_C_OUT: begin
        cmd_o.op        = sbnd_pkg::OP_C_OUT;
        cmd_o.pair_addr = 1'b1;
        cmd_o.odd_sel   = 1'b1;
      end
      sbnd_pkg::ST_C_HOLD: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = stat_i.pair_last ? sbnd_pkg::OP_C_END : sbnd_pkg::OP_C_NEXT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbnd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/spectrum_bandpass_normalize_decimate.sv
// Top level of the spectrum bandpass correction, normalization and decimation block.
// Samples arrive one channel at a time, channel 0 first. A learn item is accepted,
// read and written back and a process item buffered; the last process item
// of a spectrum then runs the end-of-spectrum passes, all through one shared
// 56-step restoring divider: bandpass correction per channel (no division when
// bandpass is off), normalization and decimation accumulation per channel (no
// division when normalization is off), and, when a decimation group closes, an
// output pass per channel pair that waits while a pair item is stalled. No clearing
// pass is needed after reset; configuration writes are taken in every cycle.
module spectrum_bandpass_normalize_decimate (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic signed [7:0]          sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [5:0]                 pair_index_o,
  output logic [31:0]                value_even_o,
  output logic [31:0]                value_odd_o,
  output logic                       saturated_o,
  output logic                       last_pair_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sbnd_pkg::REG_W-1:0] cfg_index_i,
  input  logic [sbnd_pkg::CFG_W-1:0] cfg_data_i
);

  sbnd_pkg::cmd_t  cmd;
  sbnd_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  sbnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sbnd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (mode_i),
    .sample_i     (sample_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pair_index_o (pair_index_o),
    .value_even_o (value_even_o),
    .value_odd_o  (value_odd_o),
    .saturated_o  (saturated_o),
    .last_pair_o  (last_pair_o)
  );

endmodule
